// ===== rtl/laps_pkg.sv =====
// laps_pkg: shared types, widths and codes for the linear aging priority selector
// used by linear_aging_priority_select and its checker; no dependencies
package laps_pkg;

  // default table depth
  localparam int TABLE_DEPTH_DEF = 64;

  // field widths
  localparam int TIME_W   = 20;
  localparam int BASE_W   = 16;
  localparam int RATE_W   = 16;
  localparam int SEV_W    = 36;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_SERVE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_ADMITTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_SERVED   = 2'd2,
    STAT_NONE     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2,
    S_DONE  = 2'd3
  } state_t;

  // one stored table entry
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [BASE_W-1:0] base;
    logic [RATE_W-1:0] rate;
  } entry_t;

endpackage

// ===== rtl/linear_aging_priority_select.sv =====
// linear_aging_priority_select: entry table in insertion order, serve picks the highest aged value
// sequence: an admit goes straight to the done state; a serve scans every stored entry, then,
//   if one was found, shifts the later entries down over the served place; then the output register
// throughput: one item at a time; one memory read port and one shared 16x20 multiplier scan one
//   entry per cycle, then one add-and-compare stage
// reset: entry count and control clear at once; table contents are not cleared, no sweep needed
module linear_aging_priority_select
  import laps_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [TIME_W-1:0]   time_req,
  input  logic [BASE_W-1:0]   base_severity,
  input  logic [RATE_W-1:0]   rate,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SEV_W-1:0]    served_severity,
  output logic [RATE_W-1:0]   served_rate
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [TIME_W-1:0] req_time;
  status_t res_status;

  // entry memory
  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;

  // read tracking
  logic rd_valid;
  logic [AW-1:0] rd_idx;

  // product stage
  logic s2_valid;
  logic [SEV_W-1:0] s2_prod;
  logic [BASE_W-1:0] s2_base;
  logic [RATE_W-1:0] s2_rate;
  logic [AW-1:0] s2_idx;

  // running best
  logic found;
  logic [AW-1:0] best_idx;
  logic [SEV_W-1:0] best_val;
  logic [RATE_W-1:0] best_rate;

  logic accept;
  logic load_out;
  logic table_full;
  logic scan_done;
  logic shift_done;
  logic [TIME_W-1:0] diff;
  logic [SEV_W-1:0] mult;
  logic [SEV_W-1:0] cand_val;
  logic better;
  logic elig;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign table_full = (count >= CW'(TABLE_DEPTH));
  assign scan_done  = (ptr >= count) && !rd_valid && !s2_valid;
  assign shift_done = (ptr >= count) && !rd_valid;

  // shared multiply on the entry just read
  assign elig = (req_time >= rd_data.arrival);
  assign diff = req_time - rd_data.arrival;
  assign mult = rd_data.rate * diff;

  // add and compare against the running best
  assign cand_val = SEV_W'(s2_base) + s2_prod;
  assign better   = s2_valid && (!found || (cand_val > best_val) ||
                    ((cand_val == best_val) && (s2_rate > best_rate)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (command == CMD_SERVE) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = found ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory port and output load control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = ptr[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = count[AW-1:0];
    wr_data  = '{arrival: time_req, base: base_severity, rate: rate};
    load_out = 1'b0;
    case (state)
      S_IDLE: begin
        wr_en = accept && (command == CMD_ADMIT) && !table_full;
      end
      S_SCAN: begin
        rd_en = (ptr < count);
      end
      S_SHIFT: begin
        rd_en   = (ptr < count);
        wr_en   = rd_valid;
        wr_addr = rd_idx - AW'(1);
        wr_data = rd_data;
      end
      S_DONE: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read pointer, read tracking and product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      s2_valid <= 1'b0;
      ptr      <= '0;
    end else begin
      rd_valid <= rd_en;
      s2_valid <= (state == S_SCAN) && rd_valid && elig;
      if (accept) begin
        ptr <= '0;
      end else if (state == S_SCAN && scan_done) begin
        ptr <= CW'(best_idx) + CW'(1);
      end else if (rd_en) begin
        ptr <= ptr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= ptr[AW-1:0];
    s2_prod <= mult;
    s2_base <= rd_data.base;
    s2_rate <= rd_data.rate;
    s2_idx  <= rd_idx;
  end

  // request capture, best tracking and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      found      <= 1'b0;
      best_val   <= '0;
      best_rate  <= '0;
      best_idx   <= '0;
      res_status <= STAT_NONE;
      req_time   <= '0;
    end else begin
      if (accept) begin
        req_time  <= time_req;
        found     <= 1'b0;
        best_val  <= '0;
        best_rate <= '0;
        if (command == CMD_SERVE) begin
          res_status <= STAT_NONE;
        end else if (table_full) begin
          res_status <= STAT_FULL;
        end else begin
          res_status <= STAT_ADMITTED;
          count      <= count + CW'(1);
        end
      end else if (state == S_SCAN) begin
        if (better) begin
          found     <= 1'b1;
          best_val  <= cand_val;
          best_rate <= s2_rate;
          best_idx  <= s2_idx;
        end
        if (scan_done && found) begin
          res_status <= STAT_SERVED;
        end
      end else if (state == S_SHIFT && shift_done) begin
        count <= count - CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status          <= res_status;
      served_severity <= best_val;
      served_rate     <= best_rate;
    end
  end

endmodule

// ===== rtl/laps_checker.sv =====
// laps_checker: port-level assertions for linear_aging_priority_select, with its bind
// depends on laps_pkg for widths and status codes
module laps_checker
  import laps_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                command,
  input logic [TIME_W-1:0]   time_req,
  input logic [BASE_W-1:0]   base_severity,
  input logic [RATE_W-1:0]   rate,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [SEV_W-1:0]    served_severity,
  input logic [RATE_W-1:0]   served_rate
);

  // block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted item");

  // admit results carry zero value and rate
  a_admit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_ADMITTED || status == STAT_FULL) |->
    served_severity == '0 && served_rate == '0)
    else $error("admit result with nonzero payload");

  // nothing eligible gives zero value and rate
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_NONE |-> served_severity == '0 && served_rate == '0)
    else $error("empty serve result with nonzero payload");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
    $stable(served_severity) && $stable(served_rate))
    else $error("stalled result changed");

endmodule

bind linear_aging_priority_select laps_checker u_laps_checker (.*);

// ===== tb/tb_linear_aging_priority_select.sv =====
// tb_linear_aging_priority_select: self-checking bench for the linear aging priority selector,
// with directed serve rules, a full-table fill, random admit/serve traffic and output hold-off
// depends on rtl/laps_pkg.sv and rtl/linear_aging_priority_select.sv
module tb_linear_aging_priority_select;
  import laps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  // slowest item: scan plus compaction of a full table
  localparam int DRAIN_CYCLES = 3 * DEPTH + 20;
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] time_req;
    logic [BASE_W-1:0] base;
    logic [RATE_W-1:0] rate;
  } request_t;

  typedef struct {
    status_t          status;
    logic [SEV_W-1:0] severity;
    logic [RATE_W-1:0] rate;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                command = CMD_ADMIT;
  logic [TIME_W-1:0]   time_req = '0;
  logic [BASE_W-1:0]   base_severity = '0;
  logic [RATE_W-1:0]   rate = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SEV_W-1:0]    served_severity;
  logic [RATE_W-1:0]   served_rate;

  // shadow copy of the waiting table, oldest first
  entry_t      waiting_entries[$];
  reply_t      due_replies[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_cnt = 0;
  logic [TIME_W-1:0] clock_now = '0;

  linear_aging_priority_select u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .time_req        (time_req),
    .base_severity   (base_severity),
    .rate            (rate),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .served_severity (served_severity),
    .served_rate     (served_rate)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall: random, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // age every arrived entry, pick the winner and update the shadow table
  function automatic reply_t age_and_select(request_t req);
    reply_t           r;
    entry_t           e;
    logic [SEV_W-1:0] aged;
    logic [SEV_W-1:0] best_val;
    logic [RATE_W-1:0] best_rate;
    int               best;
    r.status   = STAT_ADMITTED;
    r.severity = '0;
    r.rate     = '0;
    best       = -1;
    best_val   = '0;
    best_rate  = '0;
    if (req.command == CMD_ADMIT) begin
      if (waiting_entries.size() >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        e.arrival = req.time_req;
        e.base    = req.base;
        e.rate    = req.rate;
        waiting_entries.insert(waiting_entries.size(), e);
      end
      return r;
    end
    for (int i = 0; i < waiting_entries.size(); i++) begin
      // entries that arrive after the service time are skipped
      if (req.time_req < waiting_entries[i].arrival) continue;
      aged = SEV_W'(waiting_entries[i].base) +
             SEV_W'(waiting_entries[i].rate) * SEV_W'(req.time_req - waiting_entries[i].arrival);
      // strict compares keep the earliest entry on a full tie
      if (best < 0 || aged > best_val ||
          (aged == best_val && waiting_entries[i].rate > best_rate)) begin
        best      = i;
        best_val  = aged;
        best_rate = waiting_entries[i].rate;
      end
    end
    if (best < 0) begin
      r.status = STAT_NONE;
    end else begin
      r.status   = STAT_SERVED;
      r.severity = best_val;
      r.rate     = best_rate;
      waiting_entries.delete(best);
    end
    return r;
  endfunction

  function automatic request_t req_of(logic cmd, logic [TIME_W-1:0] t,
                                      logic [BASE_W-1:0] b, logic [RATE_W-1:0] rt);
    request_t r;
    r.command  = cmd;
    r.time_req = t;
    r.base     = b;
    r.rate     = rt;
    return r;
  endfunction

  // mostly coherent traffic around a running service time, some noise
  function automatic request_t random_request(int unsigned admit_pct);
    request_t r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    r.command  = ($urandom_range(0, 99) < admit_pct) ? CMD_ADMIT : CMD_SERVE;
    r.base     = BASE_W'($urandom);
    r.rate     = RATE_W'($urandom);
    if (sel < 6) begin
      r.command  = ($urandom_range(0, 1) == 0) ? CMD_ADMIT : CMD_SERVE;
      r.time_req = TIME_W'($urandom);
      return r;
    end
    // advance time, now and then jump anywhere in the range
    if ($urandom_range(0, 99) < 2) clock_now = TIME_W'($urandom);
    else clock_now = clock_now + TIME_W'($urandom_range(0, 40));
    if (r.command == CMD_SERVE) begin
      r.time_req = clock_now;
    end else if ($urandom_range(0, 9) == 0) begin
      r.time_req = clock_now + TIME_W'($urandom_range(1, 50));
    end else begin
      r.time_req = clock_now - TIME_W'($urandom_range(0, 30));
    end
    // small values make ties likely
    case ($urandom_range(0, 3))
      0: r.base = BASE_W'($urandom_range(0, 3));
      1: r.base = (sel < 50) ? '1 : '0;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: r.rate = RATE_W'($urandom_range(0, 3));
      1: r.rate = (sel < 50) ? '1 : '0;
      default: ;
    endcase
    return r;
  endfunction

  // offer one item; valid stays high afterwards unless the next item idles first
  task automatic send_item(request_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= req.command;
    time_req      <= req.time_req;
    base_severity <= req.base;
    rate          <= req.rate;
    do @(posedge clk); while (in_stall !== 1'b0);
    due_replies.insert(due_replies.size(), age_and_select(req));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_replies.size() == 0) begin
        $error("result with nothing expected: status %0d", status);
        fail_count++;
      end else begin
        exp_r = due_replies.pop_front();
        if (status !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, status);
          fail_count++;
        end
        if (served_severity !== exp_r.severity) begin
          $error("served_severity expected %0d got %0d", exp_r.severity, served_severity);
          fail_count++;
        end
        if (served_rate !== exp_r.rate) begin
          $error("served_rate expected %0d got %0d", exp_r.rate, served_rate);
          fail_count++;
        end
      end
    end
  end

  // empty table, zero priority, extremes, entries not yet arrived, both tie rules
  task automatic test_serve_rules();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(req_of(CMD_SERVE, 20'd5, '0, '0));
    send_item(req_of(CMD_ADMIT, '0, '0, '0));
    send_item(req_of(CMD_SERVE, '0, '0, '0));
    send_item(req_of(CMD_ADMIT, '1, '1, '1));
    send_item(req_of(CMD_ADMIT, '0, '1, '1));
    send_item(req_of(CMD_SERVE, '0, '0, '0));
    send_item(req_of(CMD_SERVE, '0, '0, '0));
    send_item(req_of(CMD_SERVE, '1, '0, '0));
    // largest possible aged value
    send_item(req_of(CMD_ADMIT, '0, '1, '1));
    send_item(req_of(CMD_SERVE, '1, '0, '0));
    // equal values, higher rate wins
    send_item(req_of(CMD_ADMIT, 20'd10, 16'd100, 16'd0));
    send_item(req_of(CMD_ADMIT, 20'd10, 16'd50, 16'd5));
    send_item(req_of(CMD_SERVE, 20'd20, '0, '0));
    send_item(req_of(CMD_SERVE, 20'd20, '0, '0));
    // equal value and rate, earliest inserted wins; the survivor shows which went
    send_item(req_of(CMD_ADMIT, 20'd10, 16'd100, 16'd1));
    send_item(req_of(CMD_ADMIT, 20'd0, 16'd90, 16'd1));
    send_item(req_of(CMD_SERVE, 20'd20, '0, '0));
    send_item(req_of(CMD_SERVE, 20'd5, '0, '0));
    wait_drain();
  endtask

  // fill to capacity, overflow twice, then serve a few
  task automatic test_full_table();
    clock_now = 20'd1000;
    while (waiting_entries.size() < DEPTH) send_item(random_request(100));
    send_item(req_of(CMD_ADMIT, 20'd7, 16'd7, 16'd7));
    send_item(req_of(CMD_ADMIT, '1, '1, '1));
    repeat (4) send_item(req_of(CMD_SERVE, clock_now, '0, '0));
    wait_drain();
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned idle_pct,
                                     int unsigned stall_p, int unsigned admit_pct);
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    repeat (n) send_item(random_request(admit_pct));
    wait_drain();
    stall_pct = 0;
  endtask

  // long output hold-off while items keep coming, so the input backs up
  task automatic test_output_hold();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 500;
    repeat (40) send_item(random_request(60));
    wait_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_serve_rules();
    test_full_table();
    test_random_traffic(150, 0, 0, 70);
    test_random_traffic(150, 0, 0, 35);
    test_random_traffic(150, 75, 0, 60);
    test_random_traffic(150, 75, 0, 40);
    test_random_traffic(150, 0, 75, 60);
    test_random_traffic(150, 0, 75, 40);
    test_random_traffic(150, 30, 30, 55);
    test_random_traffic(150, 30, 30, 45);
    test_output_hold();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
